### rtl/vertex_dedup_with_bounding_box_unit_macros.svh
// Assertion macros for the vertex dedup unit; empty when synthesizing.
`ifndef VERTEX_DEDUP_WITH_BOUNDING_BOX_UNIT_MACROS_SVH
`define VERTEX_DEDUP_WITH_BOUNDING_BOX_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define VDBB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vertex dedup unit: implication check failed");

// The condition must never be true outside reset.
`define VDBB_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("vertex dedup unit: forbidden condition seen");

`else

`define VDBB_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define VDBB_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

### rtl/vdbb_pkg.sv
// Shared types and constants for the vertex dedup unit.
`timescale 1ns / 1ps

package vdbb_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int COORD_W          = 32;
  localparam int TOL_W            = 16;
  localparam int COUNT_OUT_W      = 11;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_z;
  } box_t;

  typedef struct packed {
    logic                      start_model;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
  } in_t;

  typedef struct packed {
    logic                      is_duplicate;
    logic                      table_full;
    logic [COUNT_OUT_W-1:0]    unique_count;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_z;
  } out_t;

endpackage

### rtl/vdbb_vertex_ram.sv
// Single write port, single registered read port store of unique vertices.
`timescale 1ns / 1ps

module vdbb_vertex_ram
  import vdbb_pkg::*;
#(
  parameter int DEPTH = MAX_VERTICES_DEF,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  vertex_t           wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output vertex_t           rd_data
);

  vertex_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/vdbb_axis_match.sv
// Tolerance compare of one vertex against one stored entry on all three axes.
`timescale 1ns / 1ps

module vdbb_axis_match
  import vdbb_pkg::*;
(
  input  vertex_t          probe,
  input  vertex_t          entry,
  input  logic [TOL_W-1:0] tolerance,
  output logic             hit
);

  // Differences are formed one bit wider than the coordinates so they never wrap.
  function automatic logic axis_close(input logic [COORD_W-1:0] a,
                                      input logic [COORD_W-1:0] b,
                                      input logic [TOL_W-1:0]   tol);
    logic [COORD_W:0] d;
    logic [COORD_W:0] mag;
    d   = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    mag = d[COORD_W] ? (~d + (COORD_W+1)'(1)) : d;
    return mag <= (COORD_W+1)'(tol);
  endfunction

  assign hit = axis_close(probe.x, entry.x, tolerance) &&
               axis_close(probe.y, entry.y, tolerance) &&
               axis_close(probe.z, entry.z, tolerance);

endmodule

### rtl/vdbb_bbox.sv
// Running bounding box over all vertices since the last start.
`timescale 1ns / 1ps

module vdbb_bbox
  import vdbb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    update,
  input  logic    clear,
  input  vertex_t vertex,
  output box_t    box
);

  localparam logic signed [COORD_W-1:0] MOST_POS = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] MOST_NEG = {1'b1, {(COORD_W-1){1'b0}}};

  box_t base;
  box_t box_next;

  always_comb begin
    base = clear ? '{MOST_POS, MOST_NEG, MOST_POS, MOST_NEG, MOST_POS, MOST_NEG} : box;
    box_next.min_x = (vertex.x < base.min_x) ? vertex.x : base.min_x;
    box_next.max_x = (vertex.x > base.max_x) ? vertex.x : base.max_x;
    box_next.min_y = (vertex.y < base.min_y) ? vertex.y : base.min_y;
    box_next.max_y = (vertex.y > base.max_y) ? vertex.y : base.max_y;
    box_next.min_z = (vertex.z < base.min_z) ? vertex.z : base.min_z;
    box_next.max_z = (vertex.z > base.max_z) ? vertex.z : base.max_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box <= '{MOST_POS, MOST_NEG, MOST_POS, MOST_NEG, MOST_POS, MOST_NEG};
    end else if (update) begin
      box <= box_next;
    end
  end

endmodule

### rtl/vertex_dedup_with_bounding_box_unit.sv
// Top level of the vertex dedup unit: search sequencer, count and result register.
//
// Usage. One input beat on in_valid/in_ready carries a vertex (signed Q16.16
// x, y, z) and a start_model flag; start_model empties the vertex table and
// resets the bounding box before the vertex is handled. One output beat on
// out_valid/out_ready answers each input beat with the duplicate flag, the
// table-full flag, the unique vertex count and the bounding box so far. The user
// must write the tolerance register through cfg_we/cfg_wdata only while idle; the
// block itself does not enforce it.
// Timing. The sequencer walks the stored table one entry per cycle through the
// registered read port of the vertex memory and the shared tolerance compare.
// Each entry read is compared once its registered data returns; the search ends
// at the first match or when every entry has been examined, then the output beat
// is loaded once the output register is free. in_ready is high only while the
// sequencer is idle, from the cycle after the output beat is loaded until the
// next acceptance, so vertices are handled one at a time.
//
// Reset clears the table count, the bounding box, the tolerance and out_valid.
// The output register holds its beat while the receiver stalls; the next vertex
// may be accepted and searched meanwhile, and only its final step waits.
`timescale 1ns / 1ps

`include "vertex_dedup_with_bounding_box_unit_macros.svh"

module vertex_dedup_with_bounding_box_unit
  import vdbb_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata
);

  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] rd_k;
  logic             pend;
  logic             dup;
  logic [TOL_W-1:0] tolerance;
  vertex_t          vtx;
  vertex_t          rd_entry;
  vertex_t          in_vtx;
  box_t             box;
  logic             hit;
  logic             accept;
  logic             issue;
  logic             out_free;
  logic             room;
  logic             store;
  logic             finish_fire;

  assign in_vtx   = '{in_data.vertex_x, in_data.vertex_y, in_data.vertex_z};
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // A read is issued each cycle while unexamined entries remain, unless the
  // entry read in the previous cycle has just matched.
  assign issue = (state == S_SEARCH) && (rd_k < count) && !(pend && hit);

  assign out_free    = !out_valid || out_ready;
  assign finish_fire = (state == S_FINISH) && out_free;
  assign room        = (count < CNT_MAX);
  assign store       = !dup && room;
  assign count_next  = store ? (count + CNT_W'(1)) : count;

  vdbb_vertex_ram #(
    .DEPTH (MAX_VERTICES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (finish_fire && store),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (vtx),
    .rd_en   (issue),
    .rd_addr (rd_k[ADDR_W-1:0]),
    .rd_data (rd_entry)
  );

  vdbb_axis_match u_match (
    .probe     (vtx),
    .entry     (rd_entry),
    .tolerance (tolerance),
    .hit       (hit)
  );

  // The box is widened at acceptance; it stays put until the next vertex.
  vdbb_bbox u_bbox (
    .clk    (clk),
    .rst    (rst),
    .update (accept),
    .clear  (accept && in_data.start_model),
    .vertex (in_vtx),
    .box    (box)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_k      <= '0;
      pend      <= 1'b0;
      dup       <= 1'b0;
      tolerance <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        tolerance <= cfg_wdata;
      end
      // A new beat loaded in the same cycle as the held one is taken keeps
      // out_valid high.
      if (finish_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            vtx   <= in_vtx;
            rd_k  <= '0;
            pend  <= 1'b0;
            state <= S_SEARCH;
            if (in_data.start_model) begin
              count <= '0;
            end
          end
        end
        S_SEARCH: begin
          pend <= issue;
          if (issue) begin
            rd_k <= rd_k + CNT_W'(1);
          end
          if (pend && hit) begin
            dup   <= 1'b1;
            state <= S_FINISH;
          end else if (!issue && !pend) begin
            dup   <= 1'b0;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_data  <= '{
              is_duplicate: dup,
              table_full:   !dup && !room,
              unique_count: COUNT_OUT_W'(count_next),
              min_x:        box.min_x,
              max_x:        box.max_x,
              min_y:        box.min_y,
              max_y:        box.max_y,
              min_z:        box.min_z,
              max_z:        box.max_z
            };
            count <= count_next;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The stored count can never pass the table depth.
  `VDBB_ASSERT_NEVER(a_count_in_range, clk, rst, count > CNT_MAX)

  // The search pointer never runs past the stored entries.
  `VDBB_ASSERT_IMPLY(a_ptr_in_range, clk, rst, state == S_SEARCH, rd_k <= count)

  // A vertex is either a duplicate or dropped for lack of room, never both.
  `VDBB_ASSERT_IMPLY(a_flags_exclusive, clk, rst, out_valid,
                     !(out_data.is_duplicate && out_data.table_full))

  // A write into the table happens only when a slot is free.
  `VDBB_ASSERT_IMPLY(a_store_has_room, clk, rst, finish_fire && !dup, room || !store)

endmodule
